// ----- design/cdou_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdou_pkg
// Shared types, constants and calendar helpers for the date offset unit.
// ----------------------------------------------------------------------------
package cdou_pkg;

  // Field widths
  localparam int OFFSET_WIDTH = 17;
  localparam int DAY_W        = 5;
  localparam int MONTH_W      = 4;
  localparam int YEAR_W       = 14;
  localparam int MODE_W       = 2;
  // Working day count: holds stored day plus offset, signed
  localparam int WDAY_W       = OFFSET_WIDTH + 1;

  localparam logic [YEAR_W:0] YEAR_LIMIT = 15'd9999;

  // Stream packing
  localparam int IN_BITS  = DAY_W + MONTH_W + YEAR_W + OFFSET_WIDTH;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = DAY_W + MONTH_W + YEAR_W + 3;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Divisibility by 25 via modular inverse: y*INV25 mod 2^14 <= DIV25_MAX
  localparam logic [YEAR_W-1:0] INV25     = 14'd7209;
  localparam logic [YEAR_W-1:0] DIV25_MAX = YEAR_W'((2**YEAR_W - 1) / 25);

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAYS_DEC  = 5'd31;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD = 2'd0,
    MODE_ADD  = 2'd1,
    MODE_CMP  = 2'd2,
    MODE_NOP  = 2'd3
  } mode_e;

  typedef struct packed {
    logic load;    // capture item and seed working date
    logic step;    // walk one month
    logic commit;  // write back and fill output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic fin;     // item finished (done or refused)
  } dp_status_t;

  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [YEAR_W-1:0] prod;
    logic              div25;
    prod  = y * INV25;
    div25 = (prod <= DIV25_MAX);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [DAY_W-1:0] days_of(input logic [MONTH_W-1:0] m,
                                               input logic leap);
    logic [DAY_W-1:0] n;
    if (m == MONTH_FEB) begin
      n = leap ? 5'd29 : 5'd28;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      n = 5'd30;
    end else begin
      n = 5'd31;
    end
    return n;
  endfunction

endpackage

// ----- design/cdou_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdou_ctrl
// Controller: input handshake, month-walk sequencing, output valid.
// ----------------------------------------------------------------------------
module cdou_ctrl
  import cdou_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!status_i.fin) begin
          cmd_o.step = 1'b1;
        end else if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- design/cdou_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdou_datapath
// Stored date, working date for the month walk, compare and output register.
// ----------------------------------------------------------------------------
module cdou_datapath
  import cdou_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctrl_cmd_t               cmd_i,
  output dp_status_t              status_o,
  input  mode_e                   mode_i,
  input  logic [DAY_W-1:0]        in_day_i,
  input  logic [MONTH_W-1:0]      in_month_i,
  input  logic [YEAR_W-1:0]       in_year_i,
  input  logic [OFFSET_WIDTH-1:0] offset_days_i,
  output logic [DAY_W-1:0]        out_day_o,
  output logic [MONTH_W-1:0]      out_month_o,
  output logic [YEAR_W-1:0]       out_year_o,
  output logic                    is_before_o,
  output logic                    is_equal_o,
  output logic                    range_error_o
);

  // Stored date (architectural state)
  logic [DAY_W-1:0]   st_day_q, st_day_d;
  logic [MONTH_W-1:0] st_month_q, st_month_d;
  logic [YEAR_W-1:0]  st_year_q, st_year_d;

  // Captured item
  mode_e              mode_q;
  logic [DAY_W-1:0]   in_day_q;
  logic [MONTH_W-1:0] in_month_q;
  logic [YEAR_W-1:0]  in_year_q;

  // Working date
  logic signed [WDAY_W-1:0] wd_q, wd_d;
  logic [MONTH_W-1:0]       wm_q, wm_d;
  logic [YEAR_W-1:0]        wy_q, wy_d;

  // Output register
  logic [DAY_W-1:0]   out_day_q;
  logic [MONTH_W-1:0] out_month_q;
  logic [YEAR_W-1:0]  out_year_q;
  logic               before_q, equal_q, err_q;

  logic                     leap;
  logic signed [WDAY_W-1:0] dim, dprev, seed;
  logic [MONTH_W-1:0]       m_prev;
  logic                     month_bad, fwd, bwd, settled;
  logic                     up_err, dn_err, add_err, add_fin;
  logic                     earlier, equal;

  assign leap      = is_leap(wy_q);
  assign m_prev    = wm_q - 4'd1;
  assign dim       = $signed({{(WDAY_W-DAY_W){1'b0}}, days_of(wm_q, leap)});
  assign dprev     = $signed({{(WDAY_W-DAY_W){1'b0}}, days_of(m_prev, leap)});
  assign month_bad = (wm_q == '0) || (wm_q > MONTH_DEC);
  assign fwd       = (wd_q > dim);
  assign bwd       = (wd_q <= $signed(WDAY_W'(0)));
  assign settled   = !fwd && !bwd;
  assign up_err    = fwd && (wm_q == MONTH_DEC) && (({1'b0, wy_q} + 15'd1) > YEAR_LIMIT);
  assign dn_err    = bwd && (wm_q == MONTH_JAN) && (wy_q == '0);
  assign add_err   = month_bad || up_err || dn_err || (settled && ({1'b0, wy_q} > YEAR_LIMIT));
  assign add_fin   = add_err || settled;

  always_comb begin
    if (mode_q == MODE_ADD) begin
      status_o.fin = add_fin;
    end else begin
      status_o.fin = 1'b1;
    end
  end

  // Seed: stored day plus sign-extended offset
  assign seed = $signed({{(WDAY_W-DAY_W){1'b0}}, st_day_q}) +
                $signed({offset_days_i[OFFSET_WIDTH-1], offset_days_i});

  // One month per step
  always_comb begin
    wd_d = wd_q;
    wm_d = wm_q;
    wy_d = wy_q;
    if (cmd_i.load) begin
      wd_d = seed;
      wm_d = st_month_q;
      wy_d = st_year_q;
    end else if (cmd_i.step) begin
      if (fwd) begin
        wd_d = wd_q - dim;
        if (wm_q == MONTH_DEC) begin
          wm_d = MONTH_JAN;
          wy_d = wy_q + 14'd1;
        end else begin
          wm_d = wm_q + 4'd1;
        end
      end else if (bwd) begin
        if (wm_q == MONTH_JAN) begin
          wm_d = MONTH_DEC;
          wy_d = wy_q - 14'd1;
          wd_d = wd_q + $signed({{(WDAY_W-DAY_W){1'b0}}, DAYS_DEC});
        end else begin
          wm_d = m_prev;
          wd_d = wd_q + dprev;
        end
      end
    end
  end

  // Compare, year first, then month, then day
  always_comb begin
    if (st_year_q != in_year_q) begin
      earlier = st_year_q < in_year_q;
    end else if (st_month_q != in_month_q) begin
      earlier = st_month_q < in_month_q;
    end else begin
      earlier = st_day_q < in_day_q;
    end
    equal = (st_year_q == in_year_q) && (st_month_q == in_month_q) &&
            (st_day_q == in_day_q);
  end

  always_comb begin
    st_day_d   = st_day_q;
    st_month_d = st_month_q;
    st_year_d  = st_year_q;
    if (cmd_i.commit) begin
      if (mode_q == MODE_LOAD) begin
        st_day_d   = in_day_q;
        st_month_d = in_month_q;
        st_year_d  = in_year_q;
      end else if (mode_q == MODE_ADD && !add_err) begin
        st_day_d   = wd_q[DAY_W-1:0];
        st_month_d = wm_q;
        st_year_d  = wy_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_day_q   <= 5'd1;
      st_month_q <= 4'd1;
      st_year_q  <= 14'd1970;
    end else begin
      st_day_q   <= st_day_d;
      st_month_q <= st_month_d;
      st_year_q  <= st_year_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wd_q <= wd_d;
    wm_q <= wm_d;
    wy_q <= wy_d;
    if (cmd_i.load) begin
      mode_q     <= mode_i;
      in_day_q   <= in_day_i;
      in_month_q <= in_month_i;
      in_year_q  <= in_year_i;
    end
    if (cmd_i.commit) begin
      out_day_q   <= st_day_d;
      out_month_q <= st_month_d;
      out_year_q  <= st_year_d;
      before_q    <= (mode_q == MODE_CMP) && earlier;
      equal_q     <= (mode_q == MODE_CMP) && equal;
      err_q       <= (mode_q == MODE_ADD) && add_err;
    end
  end

  assign out_day_o     = out_day_q;
  assign out_month_o   = out_month_q;
  assign out_year_o    = out_year_q;
  assign is_before_o   = before_q;
  assign is_equal_o    = equal_q;
  assign range_error_o = err_q;

endmodule

// ----- design/calendar_date_offset_unit.sv -----
`timescale 1ns / 1ps
// Sequence: a load, compare or no-op item commits once the output register is free.
// An add item first walks one month per cycle, about |offset|/30.4 months, then commits;
//   the worst case offset of -65536 days walks about 2150 months.
// Flow: one item at a time; the next item is taken once the result is
//   registered, even while that result still waits on the output side.
// Reset (rst_ni low, async): stored date 1970-01-01, no result pending, input ready.
// ----------------------------------------------------------------------------
// calendar_date_offset_unit
// Gregorian date register with load, signed day add, compare and no-op commands.
// ----------------------------------------------------------------------------
module calendar_date_offset_unit
  import cdou_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Command stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: in_day[4:0], in_month[8:5], in_year[22:9], offset_days[39:23]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: mode[1:0]
  input  logic [MODE_W-1:0]      s_axis_tuser,
  // Result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: out_day[4:0], out_month[8:5], out_year[22:9], is_before[23],
  //        is_equal[24], range_error[25], zero fill above
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int MON_LO = DAY_W;
  localparam int YR_LO  = DAY_W + MONTH_W;
  localparam int OFF_LO = YR_LO + YEAR_W;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  logic [DAY_W-1:0]   out_day;
  logic [MONTH_W-1:0] out_month;
  logic [YEAR_W-1:0]  out_year;
  logic               is_before, is_equal, range_error;

  // Controller: sequencing only, never sees payload
  cdou_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: date state, month walk, compare, output register
  cdou_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .mode_i        (mode_e'(s_axis_tuser)),
    .in_day_i      (s_axis_tdata[DAY_W-1:0]),
    .in_month_i    (s_axis_tdata[MON_LO +: MONTH_W]),
    .in_year_i     (s_axis_tdata[YR_LO +: YEAR_W]),
    .offset_days_i (s_axis_tdata[OFF_LO +: OFFSET_WIDTH]),
    .out_day_o     (out_day),
    .out_month_o   (out_month),
    .out_year_o    (out_year),
    .is_before_o   (is_before),
    .is_equal_o    (is_equal),
    .range_error_o (range_error)
  );

  assign m_axis_tdata = OUT_TDATA_W'({range_error, is_equal, is_before,
                                      out_year, out_month, out_day});

`ifndef NO_ASSERTIONS
  // One item in flight: no accept in the cycle after an accept
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while previous item still in work");

  // Before and equal are exclusive
  a_cmp_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(is_before && is_equal))
    else $error("is_before and is_equal both set");

  // A refused add carries no compare flags
  a_err_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && range_error |-> !is_before && !is_equal)
    else $error("range_error with compare flags");

  // Commit only when the output register can take the result
  a_commit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> status.fin && (!m_axis_tvalid || m_axis_tready))
    else $error("commit without finished item or free output slot");
`endif

endmodule
